@@ src/csrt_pkg.sv @@
// Shared types and constants of the cycle slot reservation table.
package csrt_pkg;

   localparam int CYCLE_BITS   = 32;
   localparam int WINDOW_SLOTS = 64;
   localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);
   localparam int MAX_UNITS    = 16;
   localparam int USAGE_BITS   = $clog2(MAX_UNITS + 1);
   localparam int UNITS_BITS   = 5;
   localparam int UNITS_RESET  = 1;

   typedef enum logic [1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_PROBE   = 2'd1,
      FUNC_ADVANCE = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_FOUND  = 2'd0,
      STAT_LIMIT  = 2'd1,
      STAT_WINDOW = 2'd2,
      STAT_EARLY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Slot store command from the sequencer.
   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [SLOT_BITS-1:0]  addr;
      logic [USAGE_BITS-1:0] wr_data;
      logic                  clr_en;
      logic                  clr_all;
      logic [SLOT_BITS-1:0]  clr_first;
      logic [SLOT_BITS-1:0]  clr_count;
   } slot_req_type;

endpackage

@@ src/csrt_ram.sv @@
// Generic single-port RAM with registered read data.
module csrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

@@ src/csrt_slots.sv @@
// Per-cycle usage counters: RAM plus valid bits that make cleared slots read as zero.
module csrt_slots (
   input  logic                            clock,
   input  logic                            reset,
   input  csrt_pkg::slot_req_type          slot_req,
   output logic [csrt_pkg::USAGE_BITS-1:0] usage
);
   import csrt_pkg::*;

   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic                    rd_valid_ff;
   logic [USAGE_BITS-1:0]   rdata;
   logic [WINDOW_SLOTS-1:0] clr_mask;
   logic [SLOT_BITS-1:0]    offset [WINDOW_SLOTS];

   csrt_ram #(
      .WIDTH(USAGE_BITS),
      .DEPTH(WINDOW_SLOTS)
   ) u_ram (
      .clock (clock),
      .en    (slot_req.rd_en | slot_req.wr_en),
      .we    (slot_req.wr_en),
      .addr  (slot_req.addr),
      .wdata (slot_req.wr_data),
      .rdata (rdata)
   );

   // Drop the slots of the cycles the base moves past.
   always_comb begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         offset[i]   = SLOT_BITS'(i) - slot_req.clr_first;
         clr_mask[i] = slot_req.clr_en &
                       (slot_req.clr_all | (offset[i] < slot_req.clr_count));
      end
      valid_in = valid_ff & ~clr_mask;
      if (slot_req.wr_en) begin
         valid_in[slot_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (slot_req.rd_en) begin
            rd_valid_ff <= valid_ff[slot_req.addr];
         end
      end
   end

   assign usage = rd_valid_ff ? rdata : '0;

endmodule

@@ src/csrt_engine.sv @@
// Sequencer that walks candidate cycles through one shared subtract/compare unit.
module csrt_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  csrt_pkg::func_type              req_func,
   input  logic [csrt_pkg::CYCLE_BITS-1:0] req_cycle,
   input  logic [csrt_pkg::CYCLE_BITS-1:0] req_limit,
   input  logic                            req_unlimited,
   input  logic [csrt_pkg::UNITS_BITS-1:0] units,
   output csrt_pkg::slot_req_type          slot_req,
   input  logic [csrt_pkg::USAGE_BITS-1:0] usage,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [csrt_pkg::CYCLE_BITS-1:0] rsp_granted,
   output csrt_pkg::status_type            rsp_status
);
   import csrt_pkg::*;

   state_type             state_ff, state_in;
   func_type              func_ff, func_in;
   logic                  unlim_ff, unlim_in;
   logic [CYCLE_BITS:0]   cand_ff, cand_in;
   logic [CYCLE_BITS:0]   last_ff, last_in;
   logic [CYCLE_BITS-1:0] base_ff, base_in;
   logic [CYCLE_BITS-1:0] grant_ff, grant_in;
   status_type            stat_ff, stat_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CYCLE_BITS-1:0] out_grant_ff, out_grant_in;
   status_type            out_stat_ff, out_stat_in;
   logic [CYCLE_BITS:0]   diff;
   logic [CYCLE_BITS:0]   cand_next;
   logic [USAGE_BITS-1:0] eff_width;
   logic                  req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;

   // Shared unit: candidate minus base, borrow in the top bit.
   assign diff      = {1'b0, cand_ff[CYCLE_BITS-1:0]} - {1'b0, base_ff};
   assign cand_next = cand_ff + 1'b1;
   assign eff_width = (32'(units) > 32'(MAX_UNITS)) ? USAGE_BITS'(MAX_UNITS)
                                                     : USAGE_BITS'(units);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      unlim_in     = unlim_ff;
      cand_in      = cand_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      grant_in     = grant_ff;
      stat_in      = stat_ff;
      out_grant_in = out_grant_ff;
      out_stat_in  = out_stat_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;

      slot_req           = '0;
      slot_req.addr      = cand_ff[SLOT_BITS-1:0];
      slot_req.wr_data   = usage + 1'b1;
      slot_req.clr_first = base_ff[SLOT_BITS-1:0];
      slot_req.clr_count = diff[SLOT_BITS-1:0];
      slot_req.clr_all   = |diff[CYCLE_BITS-1:SLOT_BITS];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_func;
               unlim_in = req_unlimited;
               cand_in  = {1'b0, req_cycle};
               last_in  = {1'b0, req_cycle} + {1'b0, req_limit};
               grant_in = '0;
               stat_in  = STAT_FOUND;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (func_ff == FUNC_NOP) begin
               state_in = ST_DONE;
            end else if (diff[CYCLE_BITS]) begin
               stat_in  = STAT_EARLY;
               state_in = ST_DONE;
            end else if (func_ff == FUNC_ADVANCE) begin
               slot_req.clr_en = 1'b1;
               base_in         = cand_ff[CYCLE_BITS-1:0];
               state_in        = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (cand_ff[CYCLE_BITS] || (|diff[CYCLE_BITS:SLOT_BITS])) begin
               stat_in  = STAT_WINDOW;
               state_in = ST_DONE;
            end else begin
               slot_req.rd_en = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (usage < eff_width) begin
               grant_in        = cand_ff[CYCLE_BITS-1:0];
               slot_req.wr_en  = (func_ff == FUNC_RESERVE);
               state_in        = ST_DONE;
            end else if (!unlim_ff && (cand_next > last_ff)) begin
               stat_in  = STAT_LIMIT;
               state_in = ST_DONE;
            end else begin
               cand_in  = cand_next;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_grant_in = grant_ff;
               out_stat_in  = stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      unlim_ff     <= unlim_in;
      cand_ff      <= cand_in;
      last_ff      <= last_in;
      grant_ff     <= grant_in;
      stat_ff      <= stat_in;
      out_grant_ff <= out_grant_in;
      out_stat_ff  <= out_stat_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_granted = out_grant_ff;
   assign rsp_status  = out_stat_ff;

   a_fire_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_START)
      else $error("accepted item did not start the sequencer");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> !cand_ff[CYCLE_BITS])
      else $error("candidate beyond cycle range reached the slot check");

   a_write_reserve: assert property (@(posedge clock) disable iff (reset)
      slot_req.wr_en |-> (state_ff == ST_CHECK) && (func_ff == FUNC_RESERVE))
      else $error("slot written outside a reserve");

   a_zero_grant: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_stat_ff != STAT_FOUND) |-> out_grant_ff == '0)
      else $error("nonzero granted cycle with failing status");

endmodule

@@ src/cycle_slot_reservation_table.sv @@
// Top level of the cycle slot reservation table.
// Advance, no-op and early-cycle requests go from the input transfer through the start and
// done states; reserve and probe also pass a read and a check state for each candidate slot
// walked, up to the whole window. One item at a time: the next transfer is taken once the
// result sits in the output register; the done state waits while a result there is unaccepted.
// Reset (synchronous): all slots zero, base 0, units_per_cycle 1.
module cycle_slot_reservation_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // cycle[31:0], search_limit[63:32], unlimited[64], zeros
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // granted_cycle[31:0], status[33:32], zeros
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data // units_per_cycle
);
   import csrt_pkg::*;

   logic [UNITS_BITS-1:0] units_ff;
   slot_req_type          slot_req;
   logic [USAGE_BITS-1:0] usage;
   logic [CYCLE_BITS-1:0] granted;
   status_type            status;

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff <= UNITS_BITS'(UNITS_RESET);
      end else if (csr_wr_en) begin
         units_ff <= csr_wr_data;
      end
   end

   csrt_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .slot_req (slot_req),
      .usage    (usage)
   );

   csrt_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_func      (func_type'(req_tuser)),
      .req_cycle     (req_tdata[31:0]),
      .req_limit     (req_tdata[63:32]),
      .req_unlimited (req_tdata[64]),
      .units         (units_ff),
      .slot_req      (slot_req),
      .usage         (usage),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_granted   (granted),
      .rsp_status    (status)
   );

   assign rsp_tdata = {6'b0, status, granted};

endmodule
